// ===== rtl/tlrs_pkg.sv =====
package tlrs_pkg;

  // field widths of the result beat
  localparam int CNT_W = 11;
  localparam int ROW_W = 10;
  localparam int PIX_W = 8;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W = 1;

  // saturation point of counters
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // reciprocal of six: (x * 683) >> 12 is x/6, >> 13 is x/12, exact for 11-bit x
  localparam logic [9:0] DIV6_MUL = 10'd683;
  localparam logic [CNT_W-1:0] END_EXTRA = CNT_W'(5);

  // register reset values
  localparam int CW_RESET = 48;
  localparam logic [CNT_W-1:0] START_RESET = CNT_W'(CW_RESET / 6);
  localparam logic [CNT_W-1:0] END_RESET = CNT_W'(CW_RESET / 12 + 5);
  localparam logic [CNT_W-1:0] MIN_GROUPS_RESET = CNT_W'(4);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GROUPS = 1'b1;

  typedef enum logic {
    KIND_SEGMENT = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  // one line store entry: raw pixel bit and pixel-and-above bit
  typedef struct packed {
    logic raw;
    logic comb;
  } line_t;

  // run detector state
  typedef struct packed {
    logic             in_band;
    logic [CNT_W-1:0] run;
    logic [ROW_W-1:0] open_start;
    logic [CNT_W-1:0] count;
  } band_t;

  typedef struct packed {
    band_t            st;
    logic             emit;
    logic [CNT_W-1:0] end_row;
  } feed_t;

  typedef struct packed {
    kind_t            kind;
    logic [ROW_W-1:0] first_row;
    logic [CNT_W-1:0] end_row;
    logic [CNT_W-1:0] total;
    logic             enough;
    logic             ovf;
    logic             last;
  } result_t;

  // one finished row through the two-phase run detector
  function automatic feed_t tlrs_feed(band_t st_in, logic [CNT_W-1:0] row, logic blank,
                                      logic is_last, logic [CNT_W-1:0] start_need,
                                      logic [CNT_W-1:0] end_need);
    feed_t            f;
    band_t            s;
    logic [CNT_W-1:0] t;
    s         = st_in;
    f.emit    = 1'b0;
    f.end_row = '0;
    t         = '0;
    if (!s.in_band) begin
      if (blank) begin
        s.run = '0;
      end else begin
        if (s.run != CNT_SAT) s.run = s.run + CNT_W'(1);
        if (s.run >= start_need) begin
          t            = row + CNT_W'(1) - s.run;
          s.open_start = t[ROW_W-1:0];
          s.run        = '0;
          s.in_band    = 1'b1;
        end
      end
    end else begin
      if (is_last) begin
        if (s.run != CNT_SAT) s.run = s.run + CNT_W'(1);
        f.emit = 1'b1;
      end else if (!blank) begin
        s.run = '0;
      end else begin
        if (s.run != CNT_SAT) s.run = s.run + CNT_W'(1);
        if (s.run >= end_need) f.emit = 1'b1;
      end
      if (f.emit) begin
        f.end_row = row + CNT_W'(2) - s.run;
        if (s.count != CNT_SAT) s.count = s.count + CNT_W'(1);
        s.run     = '0;
        s.in_band = 1'b0;
      end
    end
    f.st = s;
    return f;
  endfunction

endpackage

// ===== rtl/text_line_row_segmenter.sv =====
// Row segmenter for binary text images. Pixels arrive one per beat in raster order, with
// the row end on in_tuser and the frame end on in_tlast; one pixel is taken every clock
// while no queued result beats hold the retire stage. The row above lives in a line store
// of MAX_COLS entries: an entry is read when the pixel is taken and written back when the
// pixel retires, with a bypass for one-column rows. A row's blankness is settled at the
// end of the row below it and fed to a band detector; a band end gives a segment beat and
// a frame end a verdict beat, up to three beats for one pixel, sent one per clock while
// out_tready is high. A pixel waits in the retire stage while result beats are still
// queued, unless the last of them is taken in that same clock, so only band and frame
// ends and a stalled result channel slow the stream. The line store is not cleared
// after reset; the first row of a frame never depends on its contents.
module text_line_row_segmenter
  import tlrs_pkg::*;
#(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // pixel channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // [7:0] pixel
  input  logic                   in_tuser,  // row_end
  input  logic                   in_tlast,  // frame_end
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // band_first_row, band_end_row, band_total,
                                            // enough_bands, size_overflow, zero fill
  output logic                   out_tuser, // kind
  output logic                   out_tlast, // last
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data
);

  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int CAW = $clog2(MAX_COLS);

  // configuration
  logic [CNT_W-1:0] start_need_r, end_need_r, min_groups_r;
  logic [20:0]      cw_prod;

  // input side counters
  logic [RW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic             in_acc, in_re, in_fe, row_ok, col_ok;

  // retire stage
  logic             s1_valid_r, s1_pix_r, s1_re_r, s1_fe_r, s1_wr_r;
  logic             s1_col0_r, s1_row0_r, s1_rowok_r;
  logic [CNT_W-1:0] s1_feed_row_r, s1_last_row_r;
  logic [CAW-1:0]   s1_addr_r;
  logic             fwd_r;
  line_t            fwd_data_r;
  logic             s1_retire;

  // line store
  line_t            rd_data, wr_data;
  logic             ram_we;

  // frame state
  logic             pending_r, held_r, cur_all_r, last_all_r, ovf_r;
  band_t            band_r;
  logic             pending_nxt, held_nxt, cur_all_nxt, last_all_nxt, ovf_nxt;
  band_t            band_nxt;

  // result queue
  result_t          res_r [3];
  result_t          slot [3];
  logic [1:0]       head_r, cnt_r, n_res;
  logic             out_acc;

  // retire stage working values
  logic             above_raw, old_comb, comb_bit, pend1, held1, cur1, pend2, last_all1;
  logic             feed_a, emit_a, emit_b;
  band_t            band_mid;
  feed_t            fr_a, fr_b;
  result_t          seg_a, seg_b, verdict;

  assign cfg_ready = 1'b1;

  // register writes, start and end runs worked out here
  assign cw_prod = 21'(cfg_data) * 21'(DIV6_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_need_r <= START_RESET;
      end_need_r   <= END_RESET;
      min_groups_r <= MIN_GROUPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHAR_WIDTH: begin
          start_need_r <= CNT_W'(cw_prod[20:12]);
          end_need_r   <= CNT_W'(cw_prod[20:13]) + END_EXTRA;
        end
        CFG_MIN_GROUPS: min_groups_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_retire = s1_valid_r && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready));
  assign in_tready = !s1_valid_r || s1_retire;
  assign in_acc    = in_tvalid && in_tready;
  assign in_fe     = in_tlast;
  assign in_re     = in_tuser || in_tlast;
  assign row_ok    = row_r < RW'(MAX_ROWS);
  assign col_ok    = col_r < CW'(MAX_COLS);

  // row and column position of the incoming pixel
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (in_fe) begin
      row_nxt = '0;
      col_nxt = '0;
    end else begin
      if (row_ok && in_re) row_nxt = row_r + RW'(1);
      if (in_re) col_nxt = '0;
      else if (row_ok && col_ok) col_nxt = col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (in_acc) s1_valid_r <= 1'b1;
      else if (s1_retire) s1_valid_r <= 1'b0;
    end
  end

  // pixel beat into the retire stage, with bypass of a write to the same column
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r      <= in_tdata[PIX_W-1:0] != '0;
      s1_re_r       <= in_re;
      s1_fe_r       <= in_fe;
      s1_wr_r       <= row_ok && col_ok;
      s1_col0_r     <= col_r == '0;
      s1_row0_r     <= row_r == '0;
      s1_rowok_r    <= row_ok;
      s1_feed_row_r <= CNT_W'(row_r - RW'(1));
      s1_last_row_r <= row_ok ? CNT_W'(row_r) : CNT_W'(row_r - RW'(1));
      s1_addr_r     <= col_r[CAW-1:0];
      fwd_r         <= ram_we && (s1_addr_r == col_r[CAW-1:0]);
      fwd_data_r    <= wr_data;
    end
  end

  // line store of the row above
  assign ram_we       = s1_retire && s1_wr_r;
  assign wr_data.raw  = s1_pix_r;
  assign wr_data.comb = comb_bit;

  tlrs_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (col_r[CAW-1:0]),
    .rdata (rd_data)
  );

  // column update, row end and frame end
  always_comb begin
    above_raw = fwd_r ? fwd_data_r.raw : rd_data.raw;
    old_comb  = fwd_r ? fwd_data_r.comb : rd_data.comb;
    comb_bit  = s1_pix_r && (s1_row0_r || above_raw);

    pend1 = pending_r;
    held1 = held_r;
    cur1  = cur_all_r;
    if (s1_wr_r) begin
      if (!s1_col0_r) pend1 = pending_r && held_r && s1_pix_r;
      held1 = old_comb;
      cur1  = cur_all_r && comb_bit;
    end
    ovf_nxt = ovf_r || !s1_wr_r;
    pend2   = pend1 && held1;

    // row above finished at this row end
    feed_a   = s1_rowok_r && s1_re_r && !s1_row0_r;
    fr_a     = tlrs_feed(band_r, s1_feed_row_r, pend2, 1'b0, start_need_r, end_need_r);
    emit_a   = feed_a && fr_a.emit;
    band_mid = feed_a ? fr_a.st : band_r;

    last_all1 = (s1_rowok_r && s1_re_r) ? cur1 : last_all_r;

    // last row at frame end
    fr_b   = tlrs_feed(band_mid, s1_last_row_r, last_all1, 1'b1, start_need_r, end_need_r);
    emit_b = s1_fe_r && fr_b.emit;

    seg_a.kind      = KIND_SEGMENT;
    seg_a.first_row = fr_a.st.open_start;
    seg_a.end_row   = fr_a.end_row;
    seg_a.total     = fr_a.st.count;
    seg_a.enough    = 1'b0;
    seg_a.ovf       = ovf_nxt;
    seg_a.last      = !s1_fe_r;

    seg_b.kind      = KIND_SEGMENT;
    seg_b.first_row = fr_b.st.open_start;
    seg_b.end_row   = fr_b.end_row;
    seg_b.total     = fr_b.st.count;
    seg_b.enough    = 1'b0;
    seg_b.ovf       = ovf_nxt;
    seg_b.last      = 1'b0;

    verdict.kind      = KIND_VERDICT;
    verdict.first_row = '0;
    verdict.end_row   = '0;
    verdict.total     = s1_fe_r ? fr_b.st.count : band_mid.count;
    verdict.enough    = verdict.total >= min_groups_r;
    verdict.ovf       = ovf_nxt;
    verdict.last      = 1'b1;

    // results packed in order of occurrence
    slot[0] = emit_a ? seg_a : (emit_b ? seg_b : verdict);
    slot[1] = (emit_a && emit_b) ? seg_b : verdict;
    slot[2] = verdict;
    n_res   = {1'b0, emit_a} + {1'b0, emit_b} + {1'b0, s1_fe_r};

    // next frame state
    if (s1_fe_r) begin
      pending_nxt  = 1'b1;
      held_nxt     = 1'b0;
      cur_all_nxt  = 1'b1;
      last_all_nxt = 1'b1;
      band_nxt     = '0;
    end else begin
      pending_nxt  = (s1_rowok_r && s1_re_r) ? 1'b1 : pend1;
      held_nxt     = held1;
      cur_all_nxt  = (s1_rowok_r && s1_re_r) ? 1'b1 : cur1;
      last_all_nxt = last_all1;
      band_nxt     = band_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b1;
      held_r     <= 1'b0;
      cur_all_r  <= 1'b1;
      last_all_r <= 1'b1;
      ovf_r      <= 1'b0;
      band_r     <= '0;
    end else if (s1_retire) begin
      pending_r  <= pending_nxt;
      held_r     <= held_nxt;
      cur_all_r  <= cur_all_nxt;
      last_all_r <= last_all_nxt;
      ovf_r      <= s1_fe_r ? 1'b0 : ovf_nxt;
      band_r     <= band_nxt;
    end
  end

  // result queue, one beat a clock while out_tready is high
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (s1_retire) begin
      head_r <= '0;
      cnt_r  <= n_res;
    end else if (out_acc) begin
      head_r <= head_r + 2'd1;
      cnt_r  <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_retire) res_r <= slot;
  end

  assign out_tvalid = cnt_r != 2'd0;
  assign out_tuser  = res_r[head_r].kind;
  assign out_tlast  = res_r[head_r].last;
  assign out_tdata  = OUT_TDATA_W'({res_r[head_r].ovf, res_r[head_r].enough,
                                    res_r[head_r].total, res_r[head_r].end_row,
                                    res_r[head_r].first_row});

endmodule

// ===== rtl/tlrs_ram.sv =====
module tlrs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tlrs_checker.sv =====
module tlrs_checker
  import tlrs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // the verdict closes the results of its pixel
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("verdict beat without tlast");

  // a verdict carries no band rows
  a_verdict_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[20:0] == '0)
    else $error("verdict beat with band rows");

  // a segment carries no verdict
  a_seg_enough: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !out_tdata[32])
    else $error("segment beat with enough_bands set");

  // a segment beat counts its own band, so its band total cannot drop below one
  a_seg_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:21] != '0)
    else $error("segment beat with zero band total");

endmodule

bind text_line_row_segmenter tlrs_checker u_tlrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== test/tb_text_line_row_segmenter.sv =====
`timescale 1ns / 100ps

module tb_text_line_row_segmenter;
  import tlrs_pkg::*;

  localparam int MAXR = 1024;
  localparam int MAXC = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED = 12;

  // frame shapes for the stimulus
  typedef enum bit [2:0] {
    SHAPE_BG,
    SHAPE_INK,
    SHAPE_STRIPES,
    SHAPE_TALL,
    SHAPE_NOISE,
    SHAPE_TEXT
  } shape_t;

  // one directed frame; the verdict is typed in only where it is obvious
  typedef struct packed {
    bit [10:0] cw;
    bit [10:0] mg;
    bit [10:0] rows;
    bit [10:0] cols;
    shape_t    shape;
    bit        fe_alone;
    bit        steady;
    bit        typed;
    bit [10:0] total;
    bit        enough;
    bit        ovf;
  } frame_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;  // [7:0] pixel
  logic                   in_tuser;  // row_end
  logic                   in_tlast;  // frame_end
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata; // band_first_row, band_end_row, band_total,
                                     // enough_bands, size_overflow, zero fill
  logic                   out_tuser; // kind
  logic                   out_tlast; // last
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CNT_W-1:0]       cfg_data;

  text_line_row_segmenter #(
    .MAX_ROWS(MAXR),
    .MAX_COLS(MAXC)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // segmenter state mirrored for prediction
  bit          ln_raw [MAXC];
  bit          ln_comb [MAXC];
  int unsigned row_idx = 0;
  int unsigned col_idx = 0;
  int unsigned run_len = 0;
  int unsigned band_cnt = 0;
  bit          acc_blank = 1'b1;
  bit          in_band = 1'b0;
  bit          ovf_seen = 1'b0;
  bit          held_above = 1'b0;
  bit          row_all = 1'b1;
  bit          prev_row_all = 1'b1;
  bit [9:0]    band_start = '0;
  int unsigned cw_reg = CW_RESET;
  int unsigned mg_reg = 4;

  result_t     beats_now[$];
  result_t     beats_due[$];
  bit          verdict_fix_en = 1'b0;
  result_t     verdict_fix;

  bit          no_gaps = 1'b0;
  int          px_sent = 0;
  int          beats_predicted = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  function automatic result_t make_beat(kind_t k, logic [ROW_W-1:0] first,
                                        logic [CNT_W-1:0] end_row, logic enough);
    result_t r;
    r.kind      = k;
    r.first_row = first;
    r.end_row   = end_row;
    r.total     = CNT_W'(band_cnt);
    r.enough    = enough;
    r.ovf       = ovf_seen;
    r.last      = 1'b0;
    return r;
  endfunction

  // one finished row through the start/end run detector
  task automatic settle_row(input int unsigned row, input bit blank, input bit is_last);
    int unsigned start_need;
    int unsigned end_need;
    bit          emit;
    start_need = cw_reg / 6;
    end_need   = cw_reg / 12 + 5;
    emit       = 1'b0;
    if (!in_band) begin
      if (blank) begin
        run_len = 0;
      end else begin
        if (run_len < CNT_SAT) run_len++;
        if (run_len >= start_need) begin
          band_start = 10'(row + 1 - run_len);
          run_len    = 0;
          in_band    = 1'b1;
        end
      end
    end else begin
      if (is_last) begin
        if (run_len < CNT_SAT) run_len++;
        emit = 1'b1;
      end else if (!blank) begin
        run_len = 0;
      end else begin
        if (run_len < CNT_SAT) run_len++;
        if (run_len >= end_need) emit = 1'b1;
      end
      if (emit) begin
        if (band_cnt < CNT_SAT) band_cnt++;
        beats_now = {beats_now, make_beat(KIND_SEGMENT, band_start,
                                          11'(row + 2 - run_len), 1'b0)};
        run_len = 0;
        in_band = 1'b0;
      end
    end
  endtask

  // per-pixel prediction, queues the beats this pixel causes
  task automatic segment_pixel(input bit [7:0] pixel, input bit row_end,
                               input bit frame_end);
    bit pix;
    bit re;
    bit comb;
    bit old;
    pix = (pixel != 8'd0);
    re  = row_end || frame_end;
    beats_now.delete();
    if (row_idx >= MAXR) begin
      ovf_seen = 1'b1;
    end else begin
      if (col_idx >= MAXC) begin
        ovf_seen = 1'b1;
      end else begin
        comb = pix && (row_idx == 0 || ln_raw[col_idx]);
        old  = ln_comb[col_idx];
        if (col_idx > 0) acc_blank = acc_blank && held_above && pix;
        held_above       = old;
        ln_raw[col_idx]  = pix;
        ln_comb[col_idx] = comb;
        row_all          = row_all && comb;
        col_idx++;
      end
      if (re) begin
        acc_blank = acc_blank && held_above;
        if (row_idx > 0) settle_row(row_idx - 1, acc_blank, 1'b0);
        prev_row_all = row_all;
        acc_blank    = 1'b1;
        row_all      = 1'b1;
        row_idx++;
      end
    end
    if (re) col_idx = 0;
    if (frame_end) begin
      settle_row(row_idx - 1, prev_row_all, 1'b1);
      beats_now = {beats_now, make_beat(KIND_VERDICT, '0, '0, band_cnt >= mg_reg)};
      // frame state back to its reset values
      row_idx      = 0;
      col_idx      = 0;
      acc_blank    = 1'b1;
      in_band      = 1'b0;
      run_len      = 0;
      band_start   = '0;
      band_cnt     = 0;
      ovf_seen     = 1'b0;
      held_above   = 1'b0;
      row_all      = 1'b1;
      prev_row_all = 1'b1;
    end
    if (beats_now.size() > 0) beats_now[beats_now.size()-1].last = 1'b1;
    foreach (beats_now[k]) begin
      if (verdict_fix_en && beats_now[k].kind == KIND_VERDICT) begin
        beats_now[k].total  = verdict_fix.total;
        beats_now[k].enough = verdict_fix.enough;
        beats_now[k].ovf    = verdict_fix.ovf;
      end
      beats_due = {beats_due, beats_now[k]};
      beats_predicted++;
    end
  endtask

  // one pixel beat, with an occasional gap in front
  task automatic push_pixel(input bit [7:0] pixel, input bit row_end, input bit frame_end);
    int gap;
    gap = (!no_gaps && $urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pixel;
    in_tuser  <= row_end;
    in_tlast  <= frame_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    segment_pixel(pixel, row_end, frame_end);
    px_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CNT_W-1:0] cw, input logic [CNT_W-1:0] mg);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CHAR_WIDTH;
    cfg_data  <= cw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cw_reg = cw;
    cfg_index <= CFG_MIN_GROUPS;
    cfg_data  <= mg;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mg_reg = mg;
    cfg_valid <= 1'b0;
  endtask

  // stream one frame in raster order
  task automatic send_frame(input int rows, input int cols, input shape_t shape,
                            input bit fe_alone, input bit ragged);
    int       w;
    int       run_left;
    bit       run_ink;
    bit       ink_row;
    bit       last_px;
    bit [7:0] bg;
    bit [7:0] p;
    run_left = 0;
    run_ink  = $urandom_range(0, 1);
    for (int r = 0; r < rows; r++) begin
      w = (ragged && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : cols;
      case (shape)
        SHAPE_INK:     ink_row = 1'b1;
        SHAPE_STRIPES: ink_row = (r % 10) < 3;
        SHAPE_TALL:    ink_row = r < rows / 2;
        SHAPE_TEXT: begin
          // alternating runs of text rows and gap rows
          if (run_left == 0) begin
            run_ink  = !run_ink;
            run_left = run_ink ? $urandom_range(1, 6) : $urandom_range(1, 9);
          end
          run_left--;
          ink_row = run_ink;
        end
        default:       ink_row = 1'b0;
      endcase
      for (int c = 0; c < w; c++) begin
        bg = 8'($urandom_range(1, 255));
        if (shape == SHAPE_NOISE) begin
          p = ($urandom_range(0, 99) < 30) ? 8'd0 : bg;
        end else if (shape == SHAPE_TEXT && ink_row) begin
          p = $urandom_range(0, 1) ? 8'd0 : bg;
        end else begin
          p = ink_row ? 8'd0 : bg;
        end
        last_px = (r == rows - 1) && (c == w - 1);
        push_pixel(p, (c == w - 1) && !(last_px && fe_alone), last_px);
      end
    end
  endtask

  // result side: random stalls, compare each beat with the oldest prediction
  always @(posedge clk) begin : check_beats
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind      = kind_t'(out_tuser);
      got.first_row = out_tdata[9:0];
      got.end_row   = out_tdata[20:10];
      got.total     = out_tdata[31:21];
      got.enough    = out_tdata[32];
      got.ovf       = out_tdata[33];
      got.last      = out_tlast;
      if (beats_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result beat: kind %0d total %0d",
                                    got.kind, got.total);
      end else begin
        want = beats_due.pop_front();
        if (got != want) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch (exp/got): kind %0d/%0d first %0d/%0d end %0d/%0d",
                     want.kind, got.kind, want.first_row, got.first_row,
                     want.end_row, got.end_row);
            $display("  total %0d/%0d enough %0d/%0d ovf %0d/%0d last %0d/%0d",
                     want.total, got.total, want.enough, got.enough,
                     want.ovf, got.ovf, want.last, got.last);
          end
        end
      end
    end
    out_tready <= no_gaps || ($urandom_range(0, 99) >= 25);
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    frame_row_t directed_frames [N_DIRECTED];
    frame_row_t f;
    int         phase;
    int         base_px;
    int         base_beats;
    bit [10:0]  cw;
    bit [10:0]  mg;
    shape_t     shape;

    // cw, mg, rows, cols, shape, fe_alone, steady, typed, total, enough, ovf
    directed_frames = '{
      // one row past the column limit, fills the whole line store
      '{11'd48, 11'd4, 11'd1, 11'd1030, SHAPE_BG, 1'b0, 1'b0, 1'b1, 11'd0, 1'b0, 1'b1},
      // background only, no band, minimum group count zero
      '{11'd48, 11'd0, 11'd4, 11'd5, SHAPE_BG, 1'b0, 1'b0, 1'b1, 11'd0, 1'b1, 1'b0},
      // single pixel frame, frame end without row end
      '{11'd48, 11'd4, 11'd1, 11'd1, SHAPE_INK, 1'b1, 1'b0, 1'b1, 11'd0, 1'b0, 1'b0},
      // one-column rows, shortest runs
      '{11'd0, 11'd1, 11'd30, 11'd1, SHAPE_STRIPES, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0},
      '{11'd0, 11'd1, 11'd30, 11'd4, SHAPE_STRIPES, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0},
      '{11'd12, 11'd2, 11'd24, 11'd3, SHAPE_STRIPES, 1'b1, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0},
      // widest characters, long start and end runs
      '{11'd1024, 11'd1, 11'd400, 11'd1, SHAPE_TALL, 1'b0, 1'b1, 1'b0, 11'd0, 1'b0, 1'b0},
      // past the row limit, band closed on the last kept row
      '{11'd48, 11'd1, 11'd1030, 11'd1, SHAPE_INK, 1'b0, 1'b1, 1'b1, 11'd1, 1'b1, 1'b1},
      // column overflow on both rows, unreachable group count
      '{11'd48, 11'd1024, 11'd2, 11'd1026, SHAPE_NOISE, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0},
      // all ink, band open from the first row up to frame end
      '{11'd0, 11'd0, 11'd8, 11'd6, SHAPE_INK, 1'b0, 1'b0, 1'b1, 11'd1, 1'b1, 1'b0},
      '{11'd30, 11'd3, 11'd40, 11'd7, SHAPE_STRIPES, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0},
      '{11'd6, 11'd2, 11'd20, 11'd2, SHAPE_NOISE, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0}
    };

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_CHAR_WIDTH;
    cfg_data   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    for (int i = 0; i < N_DIRECTED; i++) begin
      f = directed_frames[i];
      if (f.cw != cw_reg || f.mg != mg_reg) begin
        wait_idle();
        write_regs(f.cw, f.mg);
      end
      no_gaps        = f.steady;
      verdict_fix    = '0;
      verdict_fix.total  = f.total;
      verdict_fix.enough = f.enough;
      verdict_fix.ovf    = f.ovf;
      verdict_fix_en = f.typed;
      send_frame(f.rows, f.cols, f.shape, f.fe_alone, 1'b0);
      verdict_fix_en = 1'b0;
    end

    // random frames in phases of six, new register settings per phase
    phase      = 0;
    base_px    = px_sent;
    base_beats = beats_predicted;
    for (int n = 0; px_sent - base_px < 320 || beats_predicted - base_beats < 40; n++) begin
      if (n % 6 == 0) begin
        wait_idle();
        no_gaps = (phase == 1);
        case ($urandom_range(0, 7))
          0:       cw = 11'd0;
          1:       cw = 11'd1024;
          default: cw = 11'($urandom_range(1, 40));
        endcase
        if ($urandom_range(0, 5) == 0) mg = $urandom_range(0, 1) ? 11'd1024 : 11'd0;
        else mg = 11'($urandom_range(0, 5));
        write_regs(cw, mg);
        phase++;
      end
      case ($urandom_range(0, 9))
        0:       shape = SHAPE_NOISE;
        1:       shape = SHAPE_BG;
        default: shape = SHAPE_TEXT;
      endcase
      send_frame($urandom_range(1, 12), $urandom_range(1, 4), shape,
                 $urandom_range(0, 4) == 0, 1'b1);
    end

    // drain
    no_gaps = 1'b0;
    in_tvalid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlrs_pkg.sv
rtl/tlrs_ram.sv
rtl/text_line_row_segmenter.sv
rtl/tlrs_checker.sv
test/tb_text_line_row_segmenter.sv
